/* rtl/cphe_pkg.sv */
`timescale 1ns / 1ps
// cphe_pkg: shared constants and types for the complex Horner evaluator
// no dependencies

package cphe_pkg;

    // coefficient register file
    localparam int NUM_COEFFS = 8;
    localparam int COEFF_W    = 64;
    localparam int CFG_ADDR_W = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_IDX_LO = 3;

    // fixed point data path
    localparam int DATA_W = 32;
    localparam int PROD_W = 2 * DATA_W;
    localparam int SUM_W  = PROD_W + 1;

    // saturated value with its clip indication
    typedef struct packed {
        logic [DATA_W-1:0] val;
        logic              clip;
    } t_sat;

endpackage

/* rtl/complex_polynomial_horner_eval_core.sv */
`timescale 1ns / 1ps
// complex_polynomial_horner_eval_core: pipelined Horner evaluation of p(z), complex Q8.24
// depends on cphe_pkg
//
// channel  | direction | handshake                        | payload
// ---------+-----------+----------------------------------+---------------------------------
// request  | in        | start & !busy                    | i_z_re, i_z_im
// result   | out       | o_valid (one cycle, no stall)    | o_value_re, o_value_im, o_saturated
// config   | in        | psel & penable & pwrite & pready | paddr, pwdata (coeff_k at 8*k)
//
// one request per cycle; busy is always low
// the pipeline is an input register, then per Horner step one
// multiply stage (four 32x32 products) and one combine/saturate/add stage
// reset (synchronous, active low) clears the valid chain and the coefficients
// the receiver cannot stall, so the pipeline never holds

module complex_polynomial_horner_eval_core #(
    parameter int MAX_DEGREE = 7,
    parameter int FRAC_BITS  = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request
    input  logic                                start,
    output logic                                busy,
    input  logic signed [cphe_pkg::DATA_W-1:0]  i_z_re,
    input  logic signed [cphe_pkg::DATA_W-1:0]  i_z_im,
    // result
    output logic                                o_valid,
    output logic signed [cphe_pkg::DATA_W-1:0]  o_value_re,
    output logic signed [cphe_pkg::DATA_W-1:0]  o_value_im,
    output logic                                o_saturated,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cphe_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [cphe_pkg::COEFF_W-1:0]        pwdata,
    output logic [cphe_pkg::COEFF_W-1:0]        prdata,
    output logic                                pready
);

    localparam int DW  = cphe_pkg::DATA_W;
    localparam int PW  = cphe_pkg::PROD_W;
    localparam int SW  = cphe_pkg::SUM_W;
    localparam int LAT = 1 + 2 * MAX_DEGREE;

    // saturate a wide signed value to the data width
    function automatic cphe_pkg::t_sat sat_wide(input logic signed [SW-1:0] x);
        cphe_pkg::t_sat r;
        if (x > SW'(signed'({1'b0, {(DW-1){1'b1}}}))) begin
            r.val  = {1'b0, {(DW-1){1'b1}}};
            r.clip = 1'b1;
        end else if (x < -SW'(signed'({2'b01, {(DW-1){1'b0}}}))) begin
            r.val  = {1'b1, {(DW-1){1'b0}}};
            r.clip = 1'b1;
        end else begin
            r.val  = x[DW-1:0];
            r.clip = 1'b0;
        end
        return r;
    endfunction

    // saturate a one-bit-grown sum to the data width
    function automatic cphe_pkg::t_sat sat_grow(input logic signed [DW:0] x);
        cphe_pkg::t_sat r;
        if (x[DW] != x[DW-1]) begin
            r.val  = x[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
            r.clip = 1'b1;
        end else begin
            r.val  = x[DW-1:0];
            r.clip = 1'b0;
        end
        return r;
    endfunction

    // coefficient registers
    logic [cphe_pkg::COEFF_W-1:0] r_coeff [cphe_pkg::NUM_COEFFS];
    logic                         w_cfg_wr;
    logic [cphe_pkg::CFG_IDX_W-1:0] w_cfg_idx;

    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_cfg_idx = paddr[cphe_pkg::CFG_IDX_LO +: cphe_pkg::CFG_IDX_W];
    assign pready    = 1'b1;
    assign prdata    = r_coeff[w_cfg_idx];
    assign busy      = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < cphe_pkg::NUM_COEFFS; i++) begin
                r_coeff[i] <= '0;
            end
        end else if (w_cfg_wr) begin
            r_coeff[w_cfg_idx] <= pwdata;
        end
    end

    // accumulator stages (stage 0 is the input register)
    logic                 r_acc_v [MAX_DEGREE+1];
    logic signed [DW-1:0] r_ar    [MAX_DEGREE+1];
    logic signed [DW-1:0] r_ai    [MAX_DEGREE+1];
    logic                 r_flag  [MAX_DEGREE+1];
    logic signed [DW-1:0] r_zr    [MAX_DEGREE+1];
    logic signed [DW-1:0] r_zi    [MAX_DEGREE+1];

    // multiply stages
    logic                 r_m_v    [MAX_DEGREE];
    logic signed [PW-1:0] r_p_rr   [MAX_DEGREE];
    logic signed [PW-1:0] r_p_ii   [MAX_DEGREE];
    logic signed [PW-1:0] r_p_ri   [MAX_DEGREE];
    logic signed [PW-1:0] r_p_ir   [MAX_DEGREE];
    logic                 r_m_flag [MAX_DEGREE];
    logic signed [DW-1:0] r_m_zr   [MAX_DEGREE];
    logic signed [DW-1:0] r_m_zi   [MAX_DEGREE];

    // input register, accumulator starts at the top coefficient
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_v[0] <= 1'b0;
        end else begin
            r_acc_v[0] <= start && !busy;
        end
        r_zr[0]   <= i_z_re;
        r_zi[0]   <= i_z_im;
        r_ar[0]   <= r_coeff[MAX_DEGREE][PW-1:DW];
        r_ai[0]   <= r_coeff[MAX_DEGREE][DW-1:0];
        r_flag[0] <= 1'b0;
    end

    for (genvar k = 0; k < MAX_DEGREE; k++) begin : g_step
        logic signed [SW-1:0] w_sum_re;
        logic signed [SW-1:0] w_sum_im;
        logic signed [SW-1:0] w_sh_re;
        logic signed [SW-1:0] w_sh_im;
        cphe_pkg::t_sat       w_pr;
        cphe_pkg::t_sat       w_pi;
        cphe_pkg::t_sat       w_ar;
        cphe_pkg::t_sat       w_ai;
        logic signed [DW-1:0] w_cr;
        logic signed [DW-1:0] w_ci;

        // multiply: four partial products of acc * z
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_m_v[k] <= 1'b0;
            end else begin
                r_m_v[k] <= r_acc_v[k];
            end
            r_p_rr[k]   <= r_ar[k] * r_zr[k];
            r_p_ii[k]   <= r_ai[k] * r_zi[k];
            r_p_ri[k]   <= r_ar[k] * r_zi[k];
            r_p_ir[k]   <= r_ai[k] * r_zr[k];
            r_m_flag[k] <= r_flag[k];
            r_m_zr[k]   <= r_zr[k];
            r_m_zi[k]   <= r_zi[k];
        end

        // combine, floor shift, saturate, add next coefficient, saturate
        assign w_cr     = r_coeff[MAX_DEGREE-1-k][PW-1:DW];
        assign w_ci     = r_coeff[MAX_DEGREE-1-k][DW-1:0];
        assign w_sum_re = SW'(r_p_rr[k]) - SW'(r_p_ii[k]);
        assign w_sum_im = SW'(r_p_ri[k]) + SW'(r_p_ir[k]);
        assign w_sh_re  = w_sum_re >>> FRAC_BITS;
        assign w_sh_im  = w_sum_im >>> FRAC_BITS;
        assign w_pr     = sat_wide(w_sh_re);
        assign w_pi     = sat_wide(w_sh_im);
        assign w_ar     = sat_grow((DW+1)'(signed'(w_pr.val)) + (DW+1)'(w_cr));
        assign w_ai     = sat_grow((DW+1)'(signed'(w_pi.val)) + (DW+1)'(w_ci));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_acc_v[k+1] <= 1'b0;
            end else begin
                r_acc_v[k+1] <= r_m_v[k];
            end
            r_ar[k+1]   <= w_ar.val;
            r_ai[k+1]   <= w_ai.val;
            r_flag[k+1] <= r_m_flag[k] || w_pr.clip || w_pi.clip || w_ar.clip || w_ai.clip;
            r_zr[k+1]   <= r_m_zr[k];
            r_zi[k+1]   <= r_m_zi[k];
        end
    end

    // result from the last accumulator stage
    assign o_valid     = r_acc_v[MAX_DEGREE];
    assign o_value_re  = r_ar[MAX_DEGREE];
    assign o_value_im  = r_ai[MAX_DEGREE];
    assign o_saturated = r_flag[MAX_DEGREE];

`ifndef SYNTHESIS
    // every result comes from an earlier accepted request
    a_res_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy && i_rst_n, LAT))
        else $error("result without matching request");

    // every accepted request gives a result at the end of the pipeline
    a_req_gives_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("request lost in pipeline");

    // a zero accumulator yields zero products in the next stage
    a_zero_prod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acc_v[0] && r_ar[0] == '0 && r_ai[0] == '0) |=>
        (r_m_v[0] && r_p_rr[0] == '0 && r_p_ii[0] == '0 &&
         r_p_ri[0] == '0 && r_p_ir[0] == '0))
        else $error("zero accumulator gave nonzero product");
`endif

endmodule

/* tb/cphe_checker.sv */
`timescale 1ns / 1ps
// cphe_checker: watches the request, result and config channels of the complex Horner
// evaluator, predicts p(z) for every accepted request and compares each result in order
// depends on cphe_pkg

module cphe_checker #(
    parameter int MAX_DEGREE = 7,
    parameter int FRAC_BITS  = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request channel
    input  logic                            start,
    input  logic                            busy,
    input  logic [cphe_pkg::DATA_W-1:0]     i_z_re,
    input  logic [cphe_pkg::DATA_W-1:0]     i_z_im,
    // result channel
    input  logic                            o_valid,
    input  logic [cphe_pkg::DATA_W-1:0]     o_value_re,
    input  logic [cphe_pkg::DATA_W-1:0]     o_value_im,
    input  logic                            o_saturated,
    // config channel
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [cphe_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [cphe_pkg::COEFF_W-1:0]    pwdata,
    // status for the top
    output int                              o_errors,
    output int                              o_pending,
    output int                              o_checked,
    output int                              o_clipped
);

    localparam int DATA_W     = cphe_pkg::DATA_W;
    localparam int SUM_W      = cphe_pkg::SUM_W;
    localparam int COEFF_W    = cphe_pkg::COEFF_W;
    localparam int NUM_COEFFS = cphe_pkg::NUM_COEFFS;
    localparam int CFG_IDX_LO = cphe_pkg::CFG_IDX_LO;
    localparam int CFG_IDX_W  = cphe_pkg::CFG_IDX_W;

    localparam int MAX_REPORTS = 10;

    // one polynomial value as the block reports it
    typedef struct packed {
        logic [DATA_W-1:0] re;
        logic [DATA_W-1:0] im;
        logic              sat;
    } t_value;

    // wide enough for an exact complex product term sum
    typedef logic signed [SUM_W:0] t_wide;

    localparam t_wide SAT_HI = {{(SUM_W + 2 - DATA_W){1'b0}}, {(DATA_W - 1){1'b1}}};
    localparam t_wide SAT_LO = ~SAT_HI;

    logic [COEFF_W-1:0] coeff_set [NUM_COEFFS];
    t_value             pending_values [$];

    function automatic t_wide widen(input logic [DATA_W-1:0] v);
        t_wide w;
        w = $signed(v);
        return w;
    endfunction

    // clip to the signed data range and say whether it clipped
    function automatic cphe_pkg::t_sat clip_q(input t_wide x);
        cphe_pkg::t_sat s;
        s.clip = (x > SAT_HI) || (x < SAT_LO);
        if (x > SAT_HI)
            s.val = SAT_HI[DATA_W-1:0];
        else if (x < SAT_LO)
            s.val = SAT_LO[DATA_W-1:0];
        else
            s.val = x[DATA_W-1:0];
        return s;
    endfunction

    // horner evaluation from the top coefficient down
    function automatic t_value horner_eval(input logic [DATA_W-1:0] z_re,
                                           input logic [DATA_W-1:0] z_im);
        t_wide          zr, zi, ar, ai, pr, pi;
        cphe_pkg::t_sat s;
        t_value         r;
        int             k;
        zr    = widen(z_re);
        zi    = widen(z_im);
        ar    = widen(coeff_set[MAX_DEGREE][COEFF_W-1:DATA_W]);
        ai    = widen(coeff_set[MAX_DEGREE][DATA_W-1:0]);
        r.sat = 1'b0;
        for (k = MAX_DEGREE; k > 0; k--) begin
            // complex product, floor-scaled back to the data format
            s     = clip_q((ar * zr - ai * zi) >>> FRAC_BITS);
            r.sat = r.sat | s.clip;
            pr    = widen(s.val);
            s     = clip_q((ar * zi + ai * zr) >>> FRAC_BITS);
            r.sat = r.sat | s.clip;
            pi    = widen(s.val);
            // add the next coefficient down
            s     = clip_q(pr + widen(coeff_set[k-1][COEFF_W-1:DATA_W]));
            r.sat = r.sat | s.clip;
            ar    = widen(s.val);
            s     = clip_q(pi + widen(coeff_set[k-1][DATA_W-1:0]));
            r.sat = r.sat | s.clip;
            ai    = widen(s.val);
        end
        r.re = ar[DATA_W-1:0];
        r.im = ai[DATA_W-1:0];
        return r;
    endfunction

    // track config, queue predictions, compare results
    always @(posedge i_clk) begin
        t_value want;
        int     idx;
        if (!i_rst_n) begin
            for (idx = 0; idx < NUM_COEFFS; idx++)
                coeff_set[idx] = '0;
            pending_values.delete();
        end else begin
            if (psel && penable && pwrite && pready)
                coeff_set[paddr[CFG_IDX_LO +: CFG_IDX_W]] = pwdata;
            if (start && !busy)
                pending_values.push_back(horner_eval(i_z_re, i_z_im));
            if (o_valid) begin
                if (pending_values.size() == 0) begin
                    o_errors++;
                    if (o_errors <= MAX_REPORTS)
                        $display("checker: unrequested result re=%h im=%h sat=%b",
                                 o_value_re, o_value_im, o_saturated);
                end else begin
                    want = pending_values.pop_front();
                    if (o_value_re !== want.re || o_value_im !== want.im
                            || o_saturated !== want.sat) begin
                        o_errors++;
                        if (o_errors <= MAX_REPORTS) begin
                            $display("checker: result %0d mismatch", o_checked);
                            $display("  expected re=%h im=%h sat=%b, got re=%h im=%h sat=%b",
                                     want.re, want.im, want.sat,
                                     o_value_re, o_value_im, o_saturated);
                        end
                    end
                    if (want.sat)
                        o_clipped++;
                    o_checked++;
                end
            end
        end
        o_pending = pending_values.size();
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// testbench: drives points and coefficient sets into the complex Horner evaluator and
// gives the verdict; prediction and comparison live in cphe_checker
// depends on cphe_pkg, cphe_checker and complex_polynomial_horner_eval_core

module testbench;

    localparam int DATA_W     = cphe_pkg::DATA_W;
    localparam int COEFF_W    = cphe_pkg::COEFF_W;
    localparam int CFG_ADDR_W = cphe_pkg::CFG_ADDR_W;
    localparam int CFG_IDX_LO = cphe_pkg::CFG_IDX_LO;
    localparam int NUM_COEFFS = cphe_pkg::NUM_COEFFS;

    localparam int MAX_DEGREE     = 7;
    localparam int FRAC_BITS      = 24;
    localparam int LATENCY        = 1 + 2 * MAX_DEGREE;
    localparam int STALL_LIMIT    = 500;
    localparam int RAND_SETS      = 10;
    localparam int POINTS_PER_SET = 125;
    localparam int NO_IDLE_SET    = 5;
    localparam int SPAN_COEF      = 32'h0200_0000;
    localparam int SPAN_Z_NEAR    = 32'h0140_0000;
    localparam int SPAN_Z_MID     = 32'h0400_0000;

    localparam logic [DATA_W-1:0] Q_ONE  = 32'h0100_0000;
    localparam logic [DATA_W-1:0] Q_HALF = 32'h0080_0000;
    localparam logic [DATA_W-1:0] Q_TWO  = 32'h0200_0000;
    localparam logic [DATA_W-1:0] Q_MAX  = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_MIN  = 32'h8000_0000;

    typedef enum int {COEF_SMALL, COEF_LOW_DEGREE, COEF_WIDE, COEF_EXTREME} t_coef_mode;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start   = 1'b0;
    logic                  busy;
    logic [DATA_W-1:0]     i_z_re  = '0;
    logic [DATA_W-1:0]     i_z_im  = '0;
    logic                  o_valid;
    logic [DATA_W-1:0]     o_value_re;
    logic [DATA_W-1:0]     o_value_im;
    logic                  o_saturated;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [COEFF_W-1:0]    pwdata  = '0;
    logic [COEFF_W-1:0]    prdata;
    logic                  pready;

    int                    n_errors, n_pending, n_checked, n_clipped;
    int                    n_sets;
    int                    idle_pct = 15;
    int                    stall_cycles;
    logic [COEFF_W-1:0]    coeff_plan [NUM_COEFFS];

    always #5 i_clk = ~i_clk;

    complex_polynomial_horner_eval_core #(
        .MAX_DEGREE(MAX_DEGREE),
        .FRAC_BITS (FRAC_BITS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_z_re     (i_z_re),
        .i_z_im     (i_z_im),
        .o_valid    (o_valid),
        .o_value_re (o_value_re),
        .o_value_im (o_value_im),
        .o_saturated(o_saturated),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    cphe_checker #(
        .MAX_DEGREE(MAX_DEGREE),
        .FRAC_BITS (FRAC_BITS)
    ) u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_z_re     (i_z_re),
        .i_z_im     (i_z_im),
        .o_valid    (o_valid),
        .o_value_re (o_value_re),
        .o_value_im (o_value_im),
        .o_saturated(o_saturated),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .o_errors   (n_errors),
        .o_pending  (n_pending),
        .o_checked  (n_checked),
        .o_clipped  (n_clipped)
    );

    // uniform value in [-span, span]
    function automatic logic [DATA_W-1:0] rand_q(input int span);
        logic [DATA_W-1:0] v;
        v = DATA_W'($urandom_range(0, 2 * span)) - DATA_W'(span);
        return v;
    endfunction

    function automatic logic [DATA_W-1:0] pick_extreme();
        case ($urandom_range(0, 5))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3:       return Q_ONE;
            4:       return -Q_ONE;
            default: return $urandom;
        endcase
    endfunction

    // mostly points near the unit circle, some wider, some anywhere
    function automatic logic [DATA_W-1:0] pick_z();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return rand_q(SPAN_Z_NEAR);
            6, 7:             return rand_q(SPAN_Z_MID);
            8:                return pick_extreme();
            default:          return $urandom;
        endcase
    endfunction

    // one request, held until taken
    task automatic send_point(input logic [DATA_W-1:0] re, input logic [DATA_W-1:0] im);
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_z_re <= re;
        i_z_im <= im;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    // stop requests, wait for every result, then let the pipeline empty
    task automatic settle();
        start <= 1'b0;
        do
            @(negedge i_clk);
        while (n_pending != 0);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    // write all coefficient registers from the plan, back to back
    task automatic load_plan();
        int k;
        for (k = 0; k < NUM_COEFFS; k++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= CFG_ADDR_W'(k << CFG_IDX_LO);
            pwdata  <= coeff_plan[k];
            @(posedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n_sets++;
    endtask

    task automatic fill_plan(input t_coef_mode mode);
        int top_k;
        int k;
        top_k = (mode == COEF_LOW_DEGREE) ? $urandom_range(0, MAX_DEGREE - 1) : MAX_DEGREE;
        for (k = 0; k < NUM_COEFFS; k++) begin
            if (k > top_k)
                coeff_plan[k] = '0;
            else begin
                case (mode)
                    COEF_SMALL, COEF_LOW_DEGREE:
                        coeff_plan[k] = {rand_q(SPAN_COEF), rand_q(SPAN_COEF)};
                    COEF_WIDE:
                        coeff_plan[k] = {$urandom, $urandom};
                    default:
                        coeff_plan[k] = {pick_extreme(), pick_extreme()};
                endcase
            end
        end
    endtask

    // stimulus and verdict
    initial begin
        int p, n, k;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // coefficients still at reset: zero polynomial, flag must stay clear
        send_point('0, '0);
        send_point(Q_MAX, Q_MAX);
        send_point(Q_MIN, Q_MIN);
        send_point(Q_MAX, Q_MIN);
        settle();

        // p(z) = z^7: unit points, doubling overflow, extreme inputs
        for (k = 0; k < NUM_COEFFS; k++)
            coeff_plan[k] = '0;
        coeff_plan[MAX_DEGREE] = {Q_ONE, {DATA_W{1'b0}}};
        load_plan();
        send_point('0, '0);
        send_point(Q_ONE, '0);
        send_point('0, Q_ONE);
        send_point(-Q_ONE, '0);
        send_point(Q_TWO, '0);
        send_point(Q_HALF, Q_HALF);
        send_point(Q_MAX, Q_MIN);
        send_point(Q_MIN, Q_MIN);
        settle();

        // extreme coefficients alternating in sign
        for (k = 0; k < NUM_COEFFS; k++)
            coeff_plan[k] = k[0] ? {Q_MIN, Q_MAX} : {Q_MAX, Q_MIN};
        load_plan();
        send_point('0, '0);
        send_point(Q_ONE, '0);
        send_point(Q_MIN, Q_MAX);
        send_point('0, Q_ONE);
        settle();

        // every coefficient minus one lsb
        for (k = 0; k < NUM_COEFFS; k++)
            coeff_plan[k] = '1;
        load_plan();
        send_point(Q_ONE, Q_ONE);
        send_point(Q_MIN, Q_MIN);
        send_point(Q_HALF, -Q_HALF);
        settle();

        // random coefficient sets, one burst without idle cycles
        for (p = 0; p < RAND_SETS; p++) begin
            fill_plan(t_coef_mode'(p % 4));
            load_plan();
            idle_pct = (p == NO_IDLE_SET) ? 0 : 15;
            for (n = 0; n < POINTS_PER_SET; n++)
                send_point(pick_z(), pick_z());
            settle();
        end

        $display("summary: %0d points checked over %0d coefficient sets, %0d saturated",
                 n_checked, n_sets, n_clipped);
        if (n_errors == 0 && n_pending == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // watchdog on cycles with no request, result or register write
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || (psel && penable && pwrite && pready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("testbench: done, errors");
            $finish;
        end else
            stall_cycles <= stall_cycles + 1;
    end

endmodule
